/* rtl/core/jts_pkg.sv */
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, token kind codes, character codes and literal word tables
// for the JSON token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jts_pkg;

  localparam int MAX_DOC_BYTES = 65536;
  localparam int QUEUE_DEPTH   = 4;

  // token kinds
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COMMA    = 4'd4;
  localparam logic [3:0] KIND_COLON    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_TRUE     = 4'd7;
  localparam logic [3:0] KIND_FALSE    = 4'd8;
  localparam logic [3:0] KIND_NULL     = 4'd9;
  localparam logic [3:0] KIND_NUMBER   = 4'd10;
  localparam logic [3:0] KIND_EOF      = 4'd11;
  localparam logic [3:0] KIND_INVALID  = 4'd12;

  // characters
  localparam logic [7:0] CH_END      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_LOWER_N  = 8'h6e;
  localparam logic [7:0] CH_LOWER_T  = 8'h74;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  // literal word selectors
  localparam logic [1:0] WORD_TRUE  = 2'd0;
  localparam logic [1:0] WORD_FALSE = 2'd1;
  localparam logic [1:0] WORD_NULL  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_LITERAL,
    MODE_ERROR
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        last_of_item;
  } token_t;

  // results of one step toward the output queue
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
    logic [7:0] ch;
    ch = CH_END;
    unique case (w)
      WORD_TRUE: begin
        case (i)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = CH_END;
        endcase
      end
      WORD_FALSE: begin
        case (i)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = CH_END;
        endcase
      end
      default: begin
        case (i)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = CH_END;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == WORD_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] lit_kind(input logic [1:0] w);
    logic [3:0] k;
    unique case (w)
      WORD_TRUE:  k = KIND_TRUE;
      WORD_FALSE: k = KIND_FALSE;
      default:    k = KIND_NULL;
    endcase
    return k;
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input logic [15:0] off,
                                    input logic [15:0] len);
    token_t t;
    t.token_kind   = kind;
    t.token_offset = off;
    t.token_length = len;
    t.last_of_item = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jts_stream_if.sv */
// ----------------------------------------------------------------------------
// jts_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface jts_stream_if #(
  parameter type data_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/jts_step.sv */
// ----------------------------------------------------------------------------
// jts_step
// Scanner state and combinational next-state logic: consumes one text byte
// and produces zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module jts_step #(
  parameter int MAX_DOC_BYTES = jts_pkg::MAX_DOC_BYTES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic [7:0]     text_byte,
  output jts_pkg::push_t      push
);

  localparam int POS_W = $clog2(MAX_DOC_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_DOC_BYTES - 1);
  localparam logic [POS_W:0]   MAX_V    = (POS_W + 1)'(MAX_DOC_BYTES);

  jts_pkg::scan_mode_t mode_r, mode_nxt, f_mode;
  logic [1:0]       lkind_r, lkind_nxt, f_lkind, word;
  logic [2:0]       lidx_r, lidx_nxt, f_lidx, lidx_inc;
  logic [POS_W-1:0] begin_r, begin_nxt, f_begin;
  logic [POS_W-1:0] pos_r, pos_nxt, f_pos;
  logic             f_emit;
  jts_pkg::token_t  f_tok;
  logic             is_digit, num_cont, lit_match, lit_done;
  jts_pkg::push_t   push_raw;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] from,
                                            input logic [POS_W-1:0] to);
    logic [POS_W:0] d;
    if (to >= from) begin
      d = {1'b0, to} - {1'b0, from};
    end else begin
      d = {1'b0, to} + MAX_V - {1'b0, from};
    end
    return d[POS_W-1:0];
  endfunction

  function automatic logic [15:0] to16(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  assign is_digit  = (text_byte >= jts_pkg::CH_ZERO) && (text_byte <= jts_pkg::CH_NINE);
  assign num_cont  = is_digit || (text_byte == jts_pkg::CH_DOT) ||
                     (text_byte == jts_pkg::CH_MINUS) || (text_byte == jts_pkg::CH_PLUS);
  assign word      = (lkind_r > jts_pkg::WORD_NULL) ? jts_pkg::WORD_NULL : lkind_r;
  assign lidx_inc  = lidx_r + 3'd1;
  assign lit_match = (lidx_r < jts_pkg::lit_len(word)) &&
                     (text_byte == jts_pkg::lit_char(word, lidx_r));
  assign lit_done  = lidx_inc >= jts_pkg::lit_len(word);

  // handling of a byte in idle mode
  always_comb begin
    f_emit  = 1'b0;
    f_tok   = jts_pkg::mk_tok(jts_pkg::KIND_INVALID, to16(pos_r), 16'd1);
    f_mode  = jts_pkg::MODE_IDLE;
    f_pos   = pos_inc(pos_r);
    f_begin = begin_r;
    f_lkind = lkind_r;
    f_lidx  = lidx_r;
    case (text_byte)
      jts_pkg::CH_LBRACE: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_LBRACE, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_RBRACE: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_RBRACE, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_LBRACKET: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_LBRACKET, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_RBRACKET: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_RBRACKET, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_COMMA: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_COMMA, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_COLON: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_COLON, to16(pos_r), 16'd1);
      end
      jts_pkg::CH_END: begin
        f_emit = 1'b1;
        f_tok  = jts_pkg::mk_tok(jts_pkg::KIND_EOF, to16(pos_r), 16'd0);
        f_pos  = '0;
      end
      jts_pkg::CH_QUOTE: begin
        f_mode  = jts_pkg::MODE_STRING;
        f_begin = pos_inc(pos_r);
      end
      jts_pkg::CH_LOWER_T, jts_pkg::CH_LOWER_F, jts_pkg::CH_LOWER_N: begin
        f_mode  = jts_pkg::MODE_LITERAL;
        f_begin = pos_r;
        f_lidx  = 3'd1;
        f_lkind = (text_byte == jts_pkg::CH_LOWER_T) ? jts_pkg::WORD_TRUE :
                  (text_byte == jts_pkg::CH_LOWER_F) ? jts_pkg::WORD_FALSE :
                                                       jts_pkg::WORD_NULL;
      end
      jts_pkg::CH_MINUS: begin
        f_mode  = jts_pkg::MODE_NUMBER;
        f_begin = pos_r;
      end
      default: begin
        if (is_digit) begin
          f_mode  = jts_pkg::MODE_NUMBER;
          f_begin = pos_r;
        end else if ((text_byte == jts_pkg::CH_SPACE) ||
                     ((text_byte >= jts_pkg::CH_TAB) && (text_byte <= jts_pkg::CH_CR))) begin
          f_emit = 1'b0;
        end else begin
          f_emit = 1'b1;
        end
      end
    endcase
  end

  // next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (fire) begin
      unique case (mode_r)
        jts_pkg::MODE_STRING: begin
          if ((text_byte == jts_pkg::CH_QUOTE) || (text_byte == jts_pkg::CH_END)) begin
            mode_nxt = jts_pkg::MODE_IDLE;
          end
        end
        jts_pkg::MODE_NUMBER: begin
          if (!num_cont) begin
            mode_nxt = f_mode;
          end
        end
        jts_pkg::MODE_LITERAL: begin
          if (!lit_match) begin
            mode_nxt = jts_pkg::MODE_ERROR;
          end else if (lit_done) begin
            mode_nxt = jts_pkg::MODE_IDLE;
          end
        end
        jts_pkg::MODE_IDLE: mode_nxt = f_mode;
        default:            mode_nxt = jts_pkg::MODE_ERROR;
      endcase
    end
  end

  // tokens and position tracking
  always_comb begin
    pos_nxt   = pos_r;
    begin_nxt = begin_r;
    lkind_nxt = lkind_r;
    lidx_nxt  = lidx_r;
    push_raw  = '0;
    if (fire) begin
      unique case (mode_r)
        jts_pkg::MODE_STRING: begin
          if (text_byte == jts_pkg::CH_QUOTE) begin
            push_raw.count = 2'd1;
            push_raw.first = jts_pkg::mk_tok(jts_pkg::KIND_STRING, to16(begin_r),
                                             to16(span(begin_r, pos_r)));
            pos_nxt = pos_inc(pos_r);
          end else if (text_byte == jts_pkg::CH_END) begin
            push_raw.count  = 2'd2;
            push_raw.first  = jts_pkg::mk_tok(jts_pkg::KIND_INVALID, to16(pos_r), 16'd0);
            push_raw.second = jts_pkg::mk_tok(jts_pkg::KIND_EOF, to16(pos_r), 16'd0);
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_inc(pos_r);
          end
        end
        jts_pkg::MODE_NUMBER: begin
          if (num_cont) begin
            pos_nxt = pos_inc(pos_r);
          end else begin
            push_raw.count  = f_emit ? 2'd2 : 2'd1;
            push_raw.first  = jts_pkg::mk_tok(jts_pkg::KIND_NUMBER, to16(begin_r),
                                              to16(span(begin_r, pos_r)));
            push_raw.second = f_tok;
            pos_nxt   = f_pos;
            begin_nxt = f_begin;
            lkind_nxt = f_lkind;
            lidx_nxt  = f_lidx;
          end
        end
        jts_pkg::MODE_LITERAL: begin
          if (lit_match) begin
            pos_nxt  = pos_inc(pos_r);
            lidx_nxt = lidx_inc;
            if (lit_done) begin
              push_raw.count = 2'd1;
              push_raw.first = jts_pkg::mk_tok(jts_pkg::lit_kind(word), to16(begin_r),
                                               16'(jts_pkg::lit_len(word)));
              lidx_nxt = 3'd0;
            end
          end else begin
            push_raw.count = 2'd1;
            push_raw.first = jts_pkg::mk_tok(jts_pkg::KIND_INVALID, to16(begin_r), 16'd0);
          end
        end
        jts_pkg::MODE_IDLE: begin
          push_raw.count = f_emit ? 2'd1 : 2'd0;
          push_raw.first = f_tok;
          pos_nxt   = f_pos;
          begin_nxt = f_begin;
          lkind_nxt = f_lkind;
          lidx_nxt  = f_lidx;
        end
        default: begin
          push_raw.count = 2'd1;
          push_raw.first = jts_pkg::mk_tok(jts_pkg::KIND_INVALID, to16(begin_r), 16'd0);
        end
      endcase
    end
  end

  // mark the final token of the byte
  always_comb begin
    push = push_raw;
    push.first.last_of_item  = (push_raw.count == 2'd1);
    push.second.last_of_item = (push_raw.count == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jts_pkg::MODE_IDLE;
      lkind_r <= '0;
      lidx_r  <= '0;
      begin_r <= '0;
      pos_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      lkind_r <= lkind_nxt;
      lidx_r  <= lidx_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == jts_pkg::MODE_ERROR |=> mode_r == jts_pkg::MODE_ERROR)
    else $error("scanner left error mode without reset");

  a_error_pos_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == jts_pkg::MODE_ERROR |=> $stable(pos_r))
    else $error("position moved in error mode");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> (mode_r == jts_pkg::MODE_STRING || mode_r == jts_pkg::MODE_NUMBER))
    else $error("two tokens from a byte outside string or number mode");

  a_literal_index: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == jts_pkg::MODE_LITERAL |-> (lidx_r != 3'd0 && lidx_r < jts_pkg::lit_len(word)))
    else $error("literal index out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/jts_out_queue.sv */
// ----------------------------------------------------------------------------
// jts_out_queue
// Small shifting token queue: takes up to two tokens per cycle, hands out
// one per request from its head slot.
// ----------------------------------------------------------------------------
`default_nettype none

module jts_out_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire jts_pkg::push_t      push,
  output logic                     room,
  output logic                     head_valid,
  input  wire logic                head_ready,
  output jts_pkg::token_t          head
);

  localparam int DEPTH = jts_pkg::QUEUE_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jts_pkg::token_t  q_r   [DEPTH];
  jts_pkg::token_t  q_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, base;
  logic             pop;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && head_ready;
  assign room       = (cnt_r <= CNT_W'(DEPTH - 2));
  assign base       = cnt_r - CNT_W'(pop);
  assign cnt_nxt    = base + CNT_W'(push.count);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = (pop && (i < DEPTH - 1)) ? q_r[(i < DEPTH - 1) ? i + 1 : i] : q_r[i];
      if ((push.count != 2'd0) && (CNT_W'(i) == base)) begin
        q_nxt[i] = push.first;
      end
      if ((push.count == 2'd2) && (CNT_W'(i) == base + CNT_W'(1))) begin
        q_nxt[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> cnt_r <= CNT_W'(DEPTH - 2))
    else $error("token pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !head_ready |=> head_valid && $stable(head))
    else $error("head token changed while waiting");
`endif

endmodule

`default_nettype wire

/* rtl/core/json_token_scanner_unit.sv */
// ----------------------------------------------------------------------------
// json_token_scanner_unit
// Streaming JSON tokenizer: one text byte per request in, tokens with kind,
// offset and length out.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                          handshake
//  in_byte    in   text_byte[7:0]                                   valid/ready
//  out_token  out  token_kind, token_offset, token_length, last     valid/ready
//
//  one byte per cycle sustained while the queue has room; two tokens from one
//  byte leave one by one. a byte passes the input register, then scanner
//  state and a four-slot token queue. input ready depends only on registered
//  state. rst_n is synchronous and returns the scanner to idle at position 0
//  with an empty queue. a stalled output backs up into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module json_token_scanner_unit #(
  parameter int MAX_DOC_BYTES = jts_pkg::MAX_DOC_BYTES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  jts_stream_if.sink    in_byte,
  jts_stream_if.source  out_token
);

  logic            byte_vld_r;
  logic [7:0]      byte_r;
  logic            room;
  logic            fire;
  logic            head_valid;
  jts_pkg::token_t head;
  jts_pkg::push_t  push;

  assign fire          = byte_vld_r && room;
  assign in_byte.ready = !byte_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_byte.ready) begin
      byte_vld_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.ready && in_byte.valid) begin
      byte_r <= in_byte.data.text_byte;
    end
  end

  jts_step #(
    .MAX_DOC_BYTES(MAX_DOC_BYTES)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (byte_r),
    .push      (push)
  );

  jts_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head_ready (out_token.ready),
    .head       (head)
  );

  assign out_token.valid = head_valid;
  assign out_token.data  = head;

endmodule

`default_nettype wire
